// ===== design/magnetometer_heading_atan2_defines.svh =====
// Assertion macros shared by the heading block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef MAGNETOMETER_HEADING_ATAN2_DEFINES_SVH
`define MAGNETOMETER_HEADING_ATAN2_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define MHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mha_pkg.sv =====
`default_nettype none

package mha_pkg;

  localparam int unsigned RAW_W               = 16;
  localparam int unsigned HEAD_W              = 16;
  localparam int unsigned VEC_GUARD           = 8;
  // Room for the rotated magnitude: sqrt(2) * CORDIC gain * 2^(15+VEC_GUARD).
  localparam int unsigned VEC_W               = RAW_W + VEC_GUARD + 3;
  localparam int unsigned ACC_FRAC            = 20;
  localparam int unsigned ACC_W               = 32;
  localparam int unsigned TABLE_LEN           = 24;
  localparam int unsigned TABLE_IDX_W         = $clog2(TABLE_LEN);
  localparam int unsigned ROTATION_STEPS_DEF  = 16;
  localparam int unsigned ANGLE_FRACTION_BITS = 7;
  localparam int          HALF_TURN_DEG       = 180;

  localparam logic signed [ACC_W-1:0] ACC_HALF_TURN =
    ACC_W'(HALF_TURN_DEG * (1 << ACC_FRAC));

  // Output window: half turn in output units, then the field's own range.
  localparam int HEAD_LIM = HALF_TURN_DEG * (1 << ANGLE_FRACTION_BITS);
  localparam int HEAD_HI  = (HEAD_LIM > 32767) ? 32767 : HEAD_LIM;
  localparam int HEAD_LO  = (HEAD_LIM > 32768) ? -32768 : -HEAD_LIM;

  localparam logic signed [HEAD_W-1:0] HEAD_HI_C = HEAD_W'(HEAD_HI);
  localparam logic signed [HEAD_W-1:0] HEAD_LO_C = HEAD_W'(HEAD_LO);

  typedef struct packed {
    logic                    zero;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
  } mha_stage_t;

  // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest.
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [TABLE_IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] val;
    val = '0;
    unique case (idx)
      5'd0:    val = ACC_W'(47185920);
      5'd1:    val = ACC_W'(27855475);
      5'd2:    val = ACC_W'(14718068);
      5'd3:    val = ACC_W'(7471121);
      5'd4:    val = ACC_W'(3750058);
      5'd5:    val = ACC_W'(1876857);
      5'd6:    val = ACC_W'(938658);
      5'd7:    val = ACC_W'(469357);
      5'd8:    val = ACC_W'(234682);
      5'd9:    val = ACC_W'(117342);
      5'd10:   val = ACC_W'(58671);
      5'd11:   val = ACC_W'(29335);
      5'd12:   val = ACC_W'(14668);
      5'd13:   val = ACC_W'(7334);
      5'd14:   val = ACC_W'(3667);
      5'd15:   val = ACC_W'(1833);
      5'd16:   val = ACC_W'(917);
      5'd17:   val = ACC_W'(458);
      5'd18:   val = ACC_W'(229);
      5'd19:   val = ACC_W'(115);
      5'd20:   val = ACC_W'(57);
      5'd21:   val = ACC_W'(29);
      5'd22:   val = ACC_W'(14);
      5'd23:   val = ACC_W'(7);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/mha_in_if.sv =====
`default_nettype none

interface mha_in_if;
  import mha_pkg::*;

  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  x_raw;
  logic [RAW_W-1:0]  y_raw;

  modport source (output valid, output x_raw, output y_raw, input ready);
  modport sink   (input valid, input x_raw, input y_raw, output ready);
endinterface

`default_nettype wire

// ===== design/mha_out_if.sv =====
`default_nettype none

interface mha_out_if;
  import mha_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [HEAD_W-1:0] heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

// ===== design/magnetometer_heading_atan2.sv =====
// Depth: NSTEPS + 1 register stages (ROTATION_STEPS capped at TABLE_LEN), one per rotation cell
//   plus the rounding output register; a stage with a free slot takes a request at once.
// Throughput: one request per cycle while the sink keeps ready high; each cell holds one vector.
// Reset: rst_ni is asynchronous, active low; it empties every stage, data regs keep content.
`default_nettype none

`include "magnetometer_heading_atan2_defines.svh"

module magnetometer_heading_atan2 #(
  parameter int unsigned ROTATION_STEPS = mha_pkg::ROTATION_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mha_in_if.sink    req_i,
  mha_out_if.source rsp_o
);
  import mha_pkg::*;

  // The angle table has TABLE_LEN entries; extra steps would add nothing.
  localparam int unsigned NSTEPS = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;

  logic       vld [NSTEPS+1];
  logic       rdy [NSTEPS+1];
  mha_stage_t stg [NSTEPS+1];

  logic signed [VEC_W-1:0] x_ext;
  logic signed [VEC_W-1:0] y_ext;
  logic signed [VEC_W-1:0] x_m;
  logic signed [VEC_W-1:0] y_m;
  logic                    flip;

  // Front end: sign-extend the readings. A vector in the left half plane is
  // turned by a half turn so the rotations only have to cover +-90 degrees;
  // the accumulator starts at +180 or -180 to match the sign of y.
  always_comb begin
    x_ext = {{(VEC_W-RAW_W){req_i.x_raw[RAW_W-1]}}, req_i.x_raw};
    y_ext = {{(VEC_W-RAW_W){req_i.y_raw[RAW_W-1]}}, req_i.y_raw};
    flip  = req_i.x_raw[RAW_W-1];
    x_m   = flip ? -x_ext : x_ext;
    y_m   = flip ? -y_ext : y_ext;

    stg[0].zero = (req_i.x_raw == '0) && (req_i.y_raw == '0);
    stg[0].x    = x_m <<< VEC_GUARD;
    stg[0].y    = y_m <<< VEC_GUARD;
    if (!flip) begin
      stg[0].acc = '0;
    end else if (req_i.y_raw[RAW_W-1]) begin
      stg[0].acc = -ACC_HALF_TURN;
    end else begin
      stg[0].acc = ACC_HALF_TURN;
    end
  end

  assign vld[0]      = req_i.valid;
  assign req_i.ready = rdy[0];

  // Rotation chain: cell k applies the k-th micro-rotation and passes its
  // vector to cell k+1; each slot stalls only when the one after it is full.
  for (genvar k = 0; k < NSTEPS; k++) begin : g_cell
    mha_cell #(
      .STEP(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[k]),
      .ready_o(rdy[k]),
      .data_i (stg[k]),
      .valid_o(vld[k+1]),
      .ready_i(rdy[k+1]),
      .data_o (stg[k+1])
    );
  end

  // Round the angle to the output fraction, clamp, and hold it for the sink.
  mha_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vld[NSTEPS]),
    .ready_o(rdy[NSTEPS]),
    .data_i (stg[NSTEPS]),
    .rsp_o  (rsp_o)
  );

  // An accepted request always lands in the first cell.
  `MHA_ASSERT_NEXT(a_accept_lands, req_i.valid && req_i.ready, vld[1], "request not captured by first cell")

  // The last cell holds its vector while the output register is full.
  `MHA_ASSERT_NEXT(a_last_cell_holds, vld[NSTEPS] && !rdy[NSTEPS], vld[NSTEPS] && $stable(stg[NSTEPS]), "last cell lost data under stall")

  // A delivered heading stays inside the half-turn window.
  `MHA_ASSERT_NOW(a_heading_range, rsp_o.valid, (rsp_o.heading <= HEAD_HI_C) && (rsp_o.heading >= HEAD_LO_C), "heading outside half turn")

endmodule

`default_nettype wire

// ===== design/mha_cell.sv =====
`default_nettype none

module mha_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  mha_pkg::mha_stage_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output mha_pkg::mha_stage_t data_o
);
  import mha_pkg::*;

  localparam logic signed [ACC_W-1:0] ANGLE = atan_entry(TABLE_IDX_W'(STEP));

  logic                    valid_q;
  mha_stage_t              data_q;
  mha_stage_t              data_d;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;

  // Rotate toward the positive x axis by atan(2^-STEP).
  always_comb begin
    xs          = data_i.x >>> STEP;
    ys          = data_i.y >>> STEP;
    data_d.zero = data_i.zero;
    if (!data_i.y[VEC_W-1]) begin
      data_d.x   = data_i.x + ys;
      data_d.y   = data_i.y - xs;
      data_d.acc = data_i.acc + ANGLE;
    end else begin
      data_d.x   = data_i.x - ys;
      data_d.y   = data_i.y + xs;
      data_d.acc = data_i.acc - ANGLE;
    end
  end

  // Take a new request whenever this slot is empty or draining.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/mha_round.sv =====
`default_nettype none

module mha_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  mha_pkg::mha_stage_t data_i,
  mha_out_if.source           rsp_o
);
  import mha_pkg::*;

  localparam int unsigned SHIFT = ACC_FRAC - ANGLE_FRACTION_BITS;
  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1 << (SHIFT - 1));
  localparam logic signed [ACC_W-1:0] ACC_HI  = ACC_W'(HEAD_HI);
  localparam logic signed [ACC_W-1:0] ACC_LO  = ACC_W'(HEAD_LO);

  logic                     valid_q;
  logic signed [HEAD_W-1:0] heading_q;
  logic signed [HEAD_W-1:0] heading_d;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-1:0]  res;

  // Round to nearest, clamp to the half turn and the field range; a zero vector gives zero.
  always_comb begin
    acc_rnd = data_i.acc + RND;
    res     = acc_rnd >>> SHIFT;
    priority if (data_i.zero) begin
      heading_d = '0;
    end else if (res > ACC_HI) begin
      heading_d = HEAD_HI_C;
    end else if (res < ACC_LO) begin
      heading_d = HEAD_LO_C;
    end else begin
      heading_d = res[HEAD_W-1:0];
    end
  end

  assign ready_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      heading_q <= heading_d;
    end
  end

  assign rsp_o.valid   = valid_q;
  assign rsp_o.heading = heading_q;

endmodule

`default_nettype wire

// ===== dv/tb_magnetometer_heading_atan2.sv =====
`timescale 1ns / 1ps

module tb_magnetometer_heading_atan2;
  import mha_pkg::*;

  // Block depth: one stage per rotation cell plus the rounding register.
  localparam int unsigned STEPS   = ROTATION_STEPS_DEF;
  localparam int unsigned LATENCY = STEPS + 1;
  // Bound on the final drain.
  localparam int unsigned DRAIN_CYCLES = 20000;
  // About 2000 requests fit easily within this bound.
  localparam longint TIMEOUT_NS = 2_000_000;

  // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest.
  localparam longint ATAN_DEG_Q20 [TABLE_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  mha_in_if  req_if ();
  mha_out_if rsp_if ();

  magnetometer_heading_atan2 #(
    .ROTATION_STEPS(STEPS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Idle rate in percent, shared by the request and the response side.
  int unsigned idle_pct = 31;
  int unsigned mismatches = 0;
  logic signed [HEAD_W-1:0] expected_headings[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Heading predictor: CORDIC vectoring on sign-extended readings.
  // The vector carries VEC_GUARD guard bits. The angle sum is in degrees
  // with ACC_FRAC fraction bits. Every right shift floors.
  function automatic logic signed [HEAD_W-1:0] heading_of(input logic [RAW_W-1:0] x_raw,
                                                           input logic [RAW_W-1:0] y_raw);
    longint vx;
    longint vy;
    longint dx;
    longint dy;
    longint angle_sum;
    longint angle;
    longint half_turn;
    vx = longint'($signed(x_raw));
    vy = longint'($signed(y_raw));
    angle_sum = 0;
    half_turn = longint'(HALF_TURN_DEG) <<< ANGLE_FRACTION_BITS;
    // Return zero for a zero vector. Its angle is undefined.
    if (vx == 0 && vy == 0) begin
      return '0;
    end
    // Fold the left half plane over. Start the angle sum at the half turn
    // that has the sign of the original y.
    if (vx < 0) begin
      angle_sum = (vy >= 0) ? (longint'(HALF_TURN_DEG) <<< ACC_FRAC)
                            : -(longint'(HALF_TURN_DEG) <<< ACC_FRAC);
      vx = -vx;
      vy = -vy;
    end
    vx = vx <<< VEC_GUARD;
    vy = vy <<< VEC_GUARD;
    for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      dx = vx >>> i;
      dy = vy >>> i;
      if (vy >= 0) begin
        vx = vx + dy;
        vy = vy - dx;
        angle_sum += ATAN_DEG_Q20[i];
      end else begin
        vx = vx - dy;
        vy = vy + dx;
        angle_sum -= ATAN_DEG_Q20[i];
      end
    end
    // Round to nearest. Clamp to the half turn, then to the 16-bit field.
    angle = (angle_sum + (longint'(1) <<< (ACC_FRAC - 1 - ANGLE_FRACTION_BITS)))
            >>> (ACC_FRAC - ANGLE_FRACTION_BITS);
    if (angle > half_turn) angle = half_turn;
    if (angle < -half_turn) angle = -half_turn;
    if (angle > 32767) angle = 32767;
    if (angle < -32768) angle = -32768;
    return angle[HEAD_W-1:0];
  endfunction

  // Return a reading in [-span, span], as the raw 16-bit pattern.
  function automatic logic [RAW_W-1:0] small_reading(input int unsigned span);
    int value;
    value = int'($urandom_range(2 * span)) - int'(span);
    return RAW_W'(value);
  endfunction

  // Drive one request at a falling edge, after random idle cycles. Hold it
  // until it is accepted, then queue its heading. Do not drop valid on the
  // way out, so that back-to-back requests keep it high.
  task automatic send_reading(input logic [RAW_W-1:0] x_raw, input logic [RAW_W-1:0] y_raw);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      req_if.x_raw <= RAW_W'($urandom);
      req_if.y_raw <= RAW_W'($urandom);
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.x_raw <= x_raw;
    req_if.y_raw <= y_raw;
    do @(posedge clk_i); while (!req_if.ready);
    expected_headings.push_back(heading_of(x_raw, y_raw));
  endtask

  // Lower valid at the next falling edge.
  task automatic pause_requests();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
  endtask

  // Response side: stall at random, sampled at each falling edge.
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Compare every accepted response with the oldest queued heading.
  always @(posedge clk_i) begin
    logic signed [HEAD_W-1:0] want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_headings.size() == 0) begin
        $error("heading: unexpected response %0d, none pending", rsp_if.heading);
        mismatches++;
      end else begin
        want = expected_headings.pop_front();
        if (rsp_if.heading !== want) begin
          $error("heading mismatch: expected %0d, actual %0d", want, rsp_if.heading);
          mismatches++;
        end
      end
    end
  end

  // Zero vector, and the smallest vectors around it.
  task automatic test_zero_vector();
    send_reading(16'h0000, 16'h0000);
    send_reading(16'h0001, 16'h0000);
    send_reading(16'h0000, 16'h0001);
    send_reading(16'hffff, 16'hffff);
  endtask

  // Full-scale readings on the axes and the diagonals, and some mixed readings off them.
  task automatic test_axes_and_extremes();
    send_reading(16'h7fff, 16'h0000);
    send_reading(16'h0000, 16'h7fff);
    send_reading(16'h0000, 16'h8000);
    send_reading(16'h7fff, 16'h7fff);
    send_reading(16'h7fff, 16'h8000);
    send_reading(16'h8000, 16'h7fff);
    send_reading(16'h8000, 16'h8000);
    send_reading(16'h0001, 16'h8000);
    send_reading(16'h7fff, 16'hffff);
    send_reading(16'haaaa, 16'h5555);
    send_reading(16'h5555, 16'haaaa);
  endtask

  // Negative x with y at or near zero. The angle sum starts at the half turn
  // here, and the CORDIC residue can push it past the clamp.
  task automatic test_half_turn_wrap();
    send_reading(16'h8000, 16'h0000);
    send_reading(16'hffff, 16'h0000);
    send_reading(16'h8123, 16'h0000);
    send_reading(16'h8000, 16'h0001);
    send_reading(16'h8000, 16'hffff);
    send_reading(16'hc000, 16'h0003);
    send_reading(16'hc000, 16'hfffd);
  endtask

  // Random readings, biased toward small vectors, the axes, the input corners and the diagonals.
  task automatic test_random_readings(input int unsigned count);
    logic [RAW_W-1:0] x_raw;
    logic [RAW_W-1:0] y_raw;
    logic [RAW_W-1:0] corners[5];
    corners = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001};
    repeat (count) begin
      case ($urandom_range(9))
        4: begin
          x_raw = small_reading(8);
          y_raw = small_reading(8);
        end
        5: begin
          // Near the negative x axis.
          x_raw = RAW_W'(16'h8000 | $urandom);
          y_raw = small_reading(64);
        end
        6: begin
          // On one axis.
          x_raw = RAW_W'($urandom);
          y_raw = '0;
          if ($urandom_range(1)) begin
            y_raw = x_raw;
            x_raw = '0;
          end
        end
        7: begin
          x_raw = corners[$urandom_range(4)];
          y_raw = corners[$urandom_range(4)];
        end
        8: begin
          // Diagonal: equal magnitude, random signs.
          x_raw = RAW_W'($urandom_range(32767));
          y_raw = $urandom_range(1) ? x_raw : -x_raw;
          if ($urandom_range(1)) x_raw = -x_raw;
        end
        default: begin
          x_raw = RAW_W'($urandom);
          y_raw = RAW_W'($urandom);
        end
      endcase
      send_reading(x_raw, y_raw);
    end
  endtask

  // Stop sending until every pending heading has come back, then resume.
  task automatic test_drain_then_resume();
    test_random_readings(25);
    pause_requests();
    while (expected_headings.size() != 0) @(posedge clk_i);
    test_random_readings(25);
  endtask

  // Run both sides without stalls so that the pipeline stays full.
  task automatic test_back_to_back();
    idle_pct = 0;
    test_random_readings(300);
    idle_pct = 31;
  endtask

  initial begin
    // Drive every input before the first edge, hold reset low, then release it at a falling edge.
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.x_raw = '0;
    req_if.y_raw = '0;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_zero_vector();
    test_axes_and_extremes();
    test_half_turn_wrap();
    test_random_readings(900);
    test_drain_then_resume();
    test_back_to_back();
    test_random_readings(600);
    pause_requests();

    // Drain the pipeline, then keep clocking so that anything extra
    // that it might still send shows up.
    for (int c = 0; c < DRAIN_CYCLES && expected_headings.size() != 0; c++) begin
      @(posedge clk_i);
    end
    repeat (2 * LATENCY) @(posedge clk_i);
    if (expected_headings.size() != 0) begin
      $error("heading: %0d responses never arrived", expected_headings.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("tb_magnetometer_heading_atan2 OK");
    end else begin
      $display("tb_magnetometer_heading_atan2 NOT OK");
    end
    $finish;
  end

  // Stop a run that hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_magnetometer_heading_atan2 NOT OK");
    $finish;
  end

endmodule
